FILE: src/gear_intake_sequencer_macros.svh
// Assertion macros used by the intake sequencer checker.
// Each macro expands to one labeled concurrent assertion on the rising clock edge.
`ifndef GEAR_INTAKE_SEQUENCER_MACROS_SVH
`define GEAR_INTAKE_SEQUENCER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GIS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("intake sequencer check failed");

// The consequent must hold in the cycle after the antecedent.
`define GIS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("intake sequencer check failed");

`endif

FILE: src/gis_pkg.sv
// Types, codes and constants of the gripper-and-roller intake sequencer.
// Used by every module of the block; depends on nothing.
package gis_pkg;

  typedef enum logic [6:0] {
    PH_IDLE    = 7'b0000001,
    PH_SEEK    = 7'b0000010,
    PH_CHEW    = 7'b0000100,
    PH_DIGEST  = 7'b0001000,
    PH_RELEASE = 7'b0010000,
    PH_POST    = 7'b0100000,
    PH_MANUAL  = 7'b1000000
  } phase_t;

  typedef enum logic [1:0] {
    RM_INTAKING = 2'd0,
    RM_INDEXING = 2'd1,
    RM_HOLDING  = 2'd2,
    RM_STOP     = 2'd3
  } rmode_t;

  // Codes reported in pickup_state.
  localparam logic [2:0] PSTATE_IDLE    = 3'd0;
  localparam logic [2:0] PSTATE_SEEK    = 3'd1;
  localparam logic [2:0] PSTATE_CHEW    = 3'd2;
  localparam logic [2:0] PSTATE_DIGEST  = 3'd3;
  localparam logic [2:0] PSTATE_RELEASE = 3'd4;
  localparam logic [2:0] PSTATE_POST    = 3'd5;
  localparam logic [2:0] PSTATE_MANUAL  = 3'd6;

  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_MANUAL = 1'b1;

  localparam logic [1:0] FLASH_NONE  = 2'd0;
  localparam logic [1:0] FLASH_SHORT = 2'd1;
  localparam logic [1:0] FLASH_LONG  = 2'd2;

  localparam logic signed [7:0] DRIVE_FULL = -8'sd100;
  localparam logic signed [7:0] DRIVE_HALF = -8'sd50;
  localparam logic signed [7:0] DRIVE_HOLD = -8'sd10;
  localparam logic signed [7:0] DRIVE_OFF  = 8'sd0;
  localparam logic [6:0] CAP_HIGH = 7'd100;
  localparam logic [6:0] CAP_LOW  = 7'd10;

  // Register indexes, taken from paddr[4:2].
  localparam logic [2:0] REG_SEEK_LEVEL  = 3'd0;
  localparam logic [2:0] REG_JAM_LEVEL   = 3'd1;
  localparam logic [2:0] REG_BOOST_LEVEL = 3'd2;
  localparam logic [2:0] REG_CHEW_TIME   = 3'd3;
  localparam logic [2:0] REG_RELEASE_TIME = 3'd4;
  localparam logic [2:0] REG_RETURN_TIME = 3'd5;

  localparam logic [10:0] SEEK_LEVEL_RST   = 11'd300;
  localparam logic [10:0] JAM_LEVEL_RST    = 11'd90;
  localparam logic [10:0] BOOST_LEVEL_RST  = 11'd50;
  localparam logic [15:0] CHEW_TIME_RST    = 16'd500;
  localparam logic [15:0] RELEASE_TIME_RST = 16'd100;
  localparam logic [15:0] RETURN_TIME_RST  = 16'd3000;

  typedef struct packed {
    logic [10:0] seek_current_level;
    logic [10:0] jam_current_level;
    logic [10:0] boost_current_level;
    logic [15:0] chew_time_ms;
    logic [15:0] release_time_ms;
    logic [15:0] return_timeout_ms;
  } gis_cfg_t;

  typedef struct packed {
    logic        op;
    logic [31:0] now_ms;
    logic [10:0] right_current;
    logic [10:0] left_current;
    logic        switch_top_left;
    logic        switch_top_right;
    logic        switch_bottom;
    logic        seek_request;
    logic        auto_release_request;
    logic        manual_release_request;
  } gis_in_t;

  typedef struct packed {
    logic [2:0]        pickup_state;
    logic              grip_close_valve;
    logic              grip_open_valve;
    logic              lower_valve;
    logic signed [7:0] roller_drive;
    logic [6:0]        roller_current_cap;
    logic [1:0]        flash_request;
    logic              lights_off_request;
    logic              item_aligned;
  } gis_out_t;

  typedef struct packed {
    phase_t            phase;
    rmode_t            rmode;
    logic [31:0]       mark_time;
    logic              grab_valve;
    logic              release_valve;
    logic              lower_pos;
    logic signed [7:0] drive;
    logic [6:0]        cap;
  } gis_state_t;

  localparam gis_state_t STATE_RST = '{
    phase:         PH_IDLE,
    rmode:         RM_HOLDING,
    mark_time:     32'd0,
    grab_valve:    1'b0,
    release_valve: 1'b0,
    lower_pos:     1'b0,
    drive:         DRIVE_OFF,
    cap:           CAP_HIGH
  };

  function automatic logic [2:0] phase_code(phase_t ph);
    logic [2:0] code;
    unique case (ph)
      PH_IDLE:    code = PSTATE_IDLE;
      PH_SEEK:    code = PSTATE_SEEK;
      PH_CHEW:    code = PSTATE_CHEW;
      PH_DIGEST:  code = PSTATE_DIGEST;
      PH_RELEASE: code = PSTATE_RELEASE;
      PH_POST:    code = PSTATE_POST;
      PH_MANUAL:  code = PSTATE_MANUAL;
      default:    code = PSTATE_IDLE;
    endcase
    return code;
  endfunction

endpackage

FILE: src/gear_intake_sequencer.sv
// Top level of the gripper-and-roller intake sequencer.
// Depends on gis_pkg, gis_cfg_regs, gis_step and gis_out_buf.
//
// One tick word is accepted per clock cycle while in_stall is low, and its result
// word is registered in the output buffer. The sequencer state (phase, roller mode,
// time mark and held valve and roller commands) is updated at the acceptance
// edge by a single pass of compare and select logic, so consecutive words
// follow each other with no gap. Results go through a two-entry buffer, so a
// word is still taken while one result waits; in_stall rises only when both
// entries are occupied. Elapsed times are taken modulo 2^32. The user must write
// registers via the APB-style port while the block is idle; it is not enforced.
module gear_intake_sequencer
  import gis_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  gis_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output gis_out_t    out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  gis_cfg_t   cfg;
  gis_state_t state_r;
  gis_state_t state_nxt;
  gis_out_t   result;
  logic       in_accept;
  logic       buf_full;

  assign in_stall  = buf_full;
  assign in_accept = in_valid && !buf_full;

  gis_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gis_step u_step (
    .cfg     (cfg),
    .in_word (in_data),
    .st      (state_r),
    .st_nxt  (state_nxt),
    .res     (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RST;
    end else if (in_accept) begin
      state_r <= state_nxt;
    end
  end

  gis_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_data (result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: src/gis_cfg_regs.sv
// Threshold and timing registers of the intake sequencer behind an APB-style port.
// Depends on gis_pkg for the register indexes, reset values and gis_cfg_t.
module gis_cfg_regs
  import gis_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output gis_cfg_t    cfg
);

  gis_cfg_t   cfg_r;
  logic [2:0] reg_idx;

  assign reg_idx = paddr[4:2];
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.seek_current_level  <= SEEK_LEVEL_RST;
      cfg_r.jam_current_level   <= JAM_LEVEL_RST;
      cfg_r.boost_current_level <= BOOST_LEVEL_RST;
      cfg_r.chew_time_ms        <= CHEW_TIME_RST;
      cfg_r.release_time_ms     <= RELEASE_TIME_RST;
      cfg_r.return_timeout_ms   <= RETURN_TIME_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_SEEK_LEVEL:   cfg_r.seek_current_level  <= pwdata[10:0];
        REG_JAM_LEVEL:    cfg_r.jam_current_level   <= pwdata[10:0];
        REG_BOOST_LEVEL:  cfg_r.boost_current_level <= pwdata[10:0];
        REG_CHEW_TIME:    cfg_r.chew_time_ms        <= pwdata[15:0];
        REG_RELEASE_TIME: cfg_r.release_time_ms     <= pwdata[15:0];
        REG_RETURN_TIME:  cfg_r.return_timeout_ms   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SEEK_LEVEL:   prdata = {21'd0, cfg_r.seek_current_level};
      REG_JAM_LEVEL:    prdata = {21'd0, cfg_r.jam_current_level};
      REG_BOOST_LEVEL:  prdata = {21'd0, cfg_r.boost_current_level};
      REG_CHEW_TIME:    prdata = {16'd0, cfg_r.chew_time_ms};
      REG_RELEASE_TIME: prdata = {16'd0, cfg_r.release_time_ms};
      REG_RETURN_TIME:  prdata = {16'd0, cfg_r.return_timeout_ms};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

FILE: src/gis_step.sv
// Next-state and result logic of the intake sequencer for one tick word.
// Depends on gis_pkg for the phase, roller mode, state and payload types.
module gis_step
  import gis_pkg::*;
(
  input  gis_cfg_t   cfg,
  input  gis_in_t    in_word,
  input  gis_state_t st,
  output gis_state_t st_nxt,
  output gis_out_t   res
);

  logic        aligned;
  logic [31:0] elapsed;
  logic        seek_hit;
  logic        jam_hit;
  logic        boost_hit;
  logic        chew_done;
  logic        release_done;
  logic        return_done;
  gis_state_t  nx;
  logic [1:0]  flash;
  logic        lights_off;

  // Drive and current limit follow the roller mode; stopping keeps the limit.
  function automatic gis_state_t set_rollers(gis_state_t s, rmode_t m, logic full);
    gis_state_t t;
    t = s;
    t.rmode = m;
    case (m)
      RM_INTAKING: begin
        t.drive = full ? DRIVE_FULL : DRIVE_HALF;
        t.cap   = CAP_HIGH;
      end
      RM_INDEXING: begin
        t.drive = DRIVE_FULL;
        t.cap   = CAP_LOW;
      end
      RM_HOLDING: begin
        t.drive = DRIVE_HOLD;
        t.cap   = CAP_LOW;
      end
      default: t.drive = DRIVE_OFF;
    endcase
    return t;
  endfunction

  // Lowering the intake always clears both gripper valves as well.
  function automatic gis_state_t lower_intake(gis_state_t s);
    gis_state_t t;
    t = s;
    t.lower_pos     = 1'b1;
    t.grab_valve    = 1'b0;
    t.release_valve = 1'b0;
    return t;
  endfunction

  assign aligned = ~(in_word.switch_top_left & in_word.switch_top_right &
                     in_word.switch_bottom);
  assign elapsed = in_word.now_ms - st.mark_time;

  assign seek_hit  = (in_word.right_current >= cfg.seek_current_level) ||
                     (in_word.left_current >= cfg.seek_current_level);
  assign jam_hit   = (in_word.right_current >= cfg.jam_current_level) ||
                     (in_word.left_current >= cfg.jam_current_level);
  assign boost_hit = (in_word.right_current > cfg.boost_current_level) &&
                     (in_word.left_current > cfg.boost_current_level);

  assign chew_done    = elapsed >= {16'd0, cfg.chew_time_ms};
  assign release_done = elapsed >= {16'd0, cfg.release_time_ms};
  assign return_done  = elapsed >= {16'd0, cfg.return_timeout_ms};

  always_comb begin
    nx         = st;
    flash      = FLASH_NONE;
    lights_off = 1'b0;
    if (in_word.op == OP_MANUAL) begin
      nx.phase = PH_MANUAL;
    end else begin
      if (nx.rmode == RM_INDEXING && aligned) begin
        nx = set_rollers(nx, RM_HOLDING, boost_hit);
      end
      unique case (st.phase)
        PH_IDLE: begin
          nx = lower_intake(nx);
          nx = set_rollers(nx, RM_STOP, boost_hit);
          if (in_word.seek_request) nx.phase = PH_SEEK;
        end
        PH_SEEK: begin
          nx = set_rollers(nx, RM_INTAKING, boost_hit);
          nx = lower_intake(nx);
          lights_off = 1'b1;
          if (seek_hit) begin
            nx.mark_time = in_word.now_ms;
            nx.phase     = PH_CHEW;
          end else if (!in_word.seek_request) begin
            nx.phase = PH_IDLE;
          end
        end
        PH_CHEW: begin
          nx = set_rollers(nx, RM_INDEXING, boost_hit);
          if (chew_done) begin
            nx       = set_rollers(nx, RM_STOP, boost_hit);
            flash    = jam_hit ? FLASH_SHORT : FLASH_LONG;
            nx.phase = PH_DIGEST;
          end
        end
        PH_DIGEST: begin
          nx = set_rollers(nx, RM_HOLDING, boost_hit);
          nx.lower_pos = 1'b0;
          if ((aligned && in_word.auto_release_request) ||
              in_word.manual_release_request) begin
            nx.mark_time = in_word.now_ms;
            flash        = FLASH_SHORT;
            nx.phase     = PH_RELEASE;
          end
        end
        PH_RELEASE: begin
          nx = set_rollers(nx, RM_STOP, boost_hit);
          nx = lower_intake(nx);
          nx.grab_valve    = 1'b1;
          nx.release_valve = 1'b1;
          if (release_done) nx.phase = PH_POST;
        end
        PH_POST: begin
          // An expired return timeout overrides a new seek request.
          if (in_word.seek_request) nx.phase = PH_SEEK;
          if (return_done) nx.phase = PH_IDLE;
        end
        PH_MANUAL: begin
          if (in_word.seek_request) nx.phase = PH_SEEK;
          if (in_word.auto_release_request || in_word.manual_release_request) begin
            nx.phase = PH_DIGEST;
          end
        end
        default: nx.phase = PH_IDLE;
      endcase
    end
  end

  assign st_nxt = nx;

  always_comb begin
    res.pickup_state       = phase_code(nx.phase);
    res.grip_close_valve   = nx.grab_valve;
    res.grip_open_valve    = nx.release_valve;
    res.lower_valve        = nx.lower_pos;
    res.roller_drive       = nx.drive;
    res.roller_current_cap = nx.cap;
    res.flash_request      = flash;
    res.lights_off_request = lights_off;
    res.item_aligned       = aligned;
  end

endmodule

FILE: src/gis_out_buf.sv
// Two-entry result buffer: an output register backed by a skid register.
// Depends on gis_pkg for the result word type gis_out_t.
module gis_out_buf
  import gis_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  gis_out_t push_data,
  output logic     full,
  output logic     out_valid,
  input  logic     out_stall,
  output gis_out_t out_data
);

  logic     main_valid_r;
  gis_out_t main_data_r;
  logic     skid_valid_r;
  gis_out_t skid_data_r;
  logic     pop;

  assign pop       = main_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      // No word can arrive while the skid entry is occupied.
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (!main_valid_r || pop) begin
      main_valid_r <= push;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) main_data_r <= skid_data_r;
    end else if (!main_valid_r || pop) begin
      main_data_r <= push_data;
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

endmodule

FILE: src/gis_checker.sv
// Port-level checks of the intake sequencer and the bind that attaches them.
// Depends on gis_pkg and the assertion macros header.
`include "gear_intake_sequencer_macros.svh"

module gis_checker
  import gis_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_stall,
  input gis_out_t out_data
);

  // A stalled result word holds until it is taken.
  `GIS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

  // Lights go off only on a seek tick, which ends in idle, seek or chew.
  `GIS_ASSERT_SAME(a_lights_phase, clk, rst_n, out_valid && out_data.lights_off_request, out_data.pickup_state == PSTATE_IDLE || out_data.pickup_state == PSTATE_SEEK || out_data.pickup_state == PSTATE_CHEW)

  // Flashes are requested only when entering digest or release.
  `GIS_ASSERT_SAME(a_flash_phase, clk, rst_n, out_valid && (out_data.flash_request != FLASH_NONE), out_data.pickup_state == PSTATE_DIGEST || out_data.pickup_state == PSTATE_RELEASE)

  // The current limit is only ever one of the two supported values.
  `GIS_ASSERT_SAME(a_cap_values, clk, rst_n, out_valid, out_data.roller_current_cap == CAP_LOW || out_data.roller_current_cap == CAP_HIGH)

endmodule

bind gear_intake_sequencer gis_checker u_gis_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
